// ===== design/sorted_list_engine_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_list_engine_macros.svh
// Assertion macros shared by the sorted list engine.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_ENGINE_MACROS_SVH
`define SORTED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define SLE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_list_engine: same-cycle check failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define SLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_list_engine: next-cycle check failed");

`endif

// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Types and codes shared by the sorted list engine controller and datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int POS_W = 4;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_REMOVE = 2'd1,
		FN_READ   = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic {
		CS_OPEN = 1'b0,
		CS_HOLD = 1'b1
	} state_t;

	typedef struct packed {
		logic    ins;
		logic    rem;
		logic    rd;
		logic    clr;
		logic    load;
		status_t status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic pos_bad;
	} stat_t;

endpackage

// ===== design/sle_ctrl.sv =====
// ----------------------------------------------------------------------------
// sle_ctrl
// Handshake controller: owns the output register state and turns each
// accepted beat into commands for the datapath.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] func,
	input  stat_t      stat,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_OPEN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		priority if (accept) begin
			state_d = CS_HOLD;
		end else if (out_ready) begin
			state_d = CS_OPEN;
		end else begin
			state_d = state_q;
		end
	end

	always_comb begin
		in_ready   = (state_q == CS_OPEN) || out_ready;
		out_valid  = (state_q == CS_HOLD);
		cmd        = '0;
		cmd.status = ST_OK;
		cmd.load   = accept;
		unique case (func_t'(func))
			FN_INSERT: begin
				if (stat.full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.ins = accept;
				end
			end
			FN_REMOVE: begin
				if (stat.pos_bad) begin
					cmd.status = ST_BAD_POS;
				end else begin
					cmd.rem = accept;
				end
			end
			FN_READ: begin
				if (stat.pos_bad) begin
					cmd.status = ST_BAD_POS;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			FN_CLEAR: begin
				cmd.clr = accept;
			end
			default: begin
				cmd.status = ST_OK;
			end
		endcase
	end

endmodule

// ===== design/sle_datapath.sv =====
// ----------------------------------------------------------------------------
// sle_datapath
// Row of sorted cells with parallel compare, one-step shift for insert and
// remove, position read, entry count and the result register.
// ----------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output stat_t                        stat,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic [POS_W-1:0]             position,
	output logic signed [DATA_WIDTH-1:0] entry,
	output logic [1:0]                   status,
	output logic [CNT_W-1:0]             count,
	output logic                         is_empty
);

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic signed [DATA_WIDTH-1:0] cells_q [CAPACITY];
	logic signed [DATA_WIDTH-1:0] ins_cell [CAPACITY];
	logic signed [DATA_WIDTH-1:0] rem_cell [CAPACITY];
	logic [CAPACITY-1:0]          lt;
	logic [CNT_W-1:0]             count_q;
	logic [CMP_W-1:0]             pos_ext;
	logic signed [DATA_WIDTH-1:0] rd_data;
	logic signed [DATA_WIDTH-1:0] entry_q;
	status_t                      status_q;

	assign pos_ext      = CMP_W'(position);
	assign stat.full    = (count_q == CNT_W'(CAPACITY));
	assign stat.pos_bad = (pos_ext >= CMP_W'(count_q));

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign lt[g] = (CNT_W'(g) < count_q) && (cells_q[g] < value);

		always_comb begin
			if (lt[g]) begin
				ins_cell[g] = cells_q[g];
			end else begin
				ins_cell[g] = value;
			end
			if (g > 0) begin
				if (!lt[g] && !lt[(g > 0) ? g - 1 : 0]) begin
					ins_cell[g] = cells_q[(g > 0) ? g - 1 : 0];
				end
			end
		end

		if (g < CAPACITY - 1) begin : g_mid
			assign rem_cell[g] = (CMP_W'(g) >= pos_ext) ? cells_q[g + 1] : cells_q[g];
		end else begin : g_last
			assign rem_cell[g] = cells_q[g];
		end
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMP_W'(i) == pos_ext) begin
				rd_data = rd_data | cells_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.ins) begin
				cells_q[i] <= ins_cell[i];
			end else if (cmd.rem) begin
				cells_q[i] <= rem_cell[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (cmd.clr) begin
				count_q <= '0;
			end else if (cmd.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			entry_q  <= cmd.rd ? rd_data : '0;
			status_q <= cmd.status;
		end
	end

	assign entry    = entry_q;
	assign status   = status_q;
	assign count    = count_q;
	assign is_empty = (count_q == '0);

endmodule

// ===== design/sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine: ascending store of signed values with insert/remove/read/clear.
// Result is registered, valid the cycle after acceptance; 1 beat per cycle while
// out_ready is high, a rate set by the parallel compare and shift across all cells.
// Reset clears the count and the output valid; cell contents stay undefined.
// ----------------------------------------------------------------------------
`include "sorted_list_engine_macros.svh"

module sorted_list_engine import sle_pkg::*; #(
	parameter int   CAPACITY   = 16,
	parameter int   DATA_WIDTH = 32,
	localparam int  CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic [POS_W-1:0]             position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] entry,
	output logic [1:0]                   status,
	output logic [CNT_W-1:0]             count,
	output logic                         is_empty
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_acc;
	logic  ins_full;
	logic  clr_acc;
	logic  rd_bad;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.func      (func),
		.stat      (stat),
		.cmd       (cmd)
	);

	sle_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH),
		.CNT_W      (CNT_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.value    (value),
		.position (position),
		.entry    (entry),
		.status   (status),
		.count    (count),
		.is_empty (is_empty)
	);

	assign in_acc   = in_valid && in_ready;
	assign ins_full = in_acc && (func == FN_INSERT) && (count == CNT_W'(CAPACITY));
	assign clr_acc  = in_acc && (func == FN_CLEAR);
	assign rd_bad   = in_acc && (func == FN_READ) && (CNT_W'(position) >= count);

	`SLE_ASSERT_IMPL(a_count_bound, 1'b1, count <= CNT_W'(CAPACITY))
	`SLE_ASSERT_NEXT(a_full_insert, ins_full, status == ST_FULL && $stable(count))
	`SLE_ASSERT_NEXT(a_clear, clr_acc, count == '0 && status == ST_OK)
	`SLE_ASSERT_NEXT(a_bad_read, rd_bad, status == ST_BAD_POS && entry == '0)

endmodule

// ===== tb/sv/sorted_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Drives insert, remove, read and clear beats into the sorted list engine and
// checks every result against a list kept in ascending order by the bench.
// A short directed part covers the extremes, equal values and bad positions;
// random bursts then fill the store past full, drain it and mix operations,
// with random gaps on both channels.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;
	import sle_pkg::*;

	localparam int DW    = 32;
	localparam int DEPTH = 16;
	localparam int CW    = 5;

	typedef struct {
		func_t               f;
		logic signed [DW-1:0] v;
		logic [POS_W-1:0]     p;
		bit                   drain;
	} op_beat_t;

	typedef struct {
		logic signed [DW-1:0] entry;
		status_t              st;
		logic [CW-1:0]        cnt;
		logic                 empty;
	} list_result_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [1:0]           func       = FN_INSERT;
	logic signed [DW-1:0] value      = '0;
	logic [POS_W-1:0]     position   = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic signed [DW-1:0] entry;
	logic [1:0]           status;
	logic [CW-1:0]        count;
	logic                 is_empty;

	op_beat_t             op_queue[$];
	list_result_t         results_due[$];
	op_beat_t             next_op;
	list_result_t         got_due;
	int                   beats_sent = 0;
	int                   errors     = 0;

	logic signed [DW-1:0] list_vals[DEPTH];
	int                   list_len   = 0;
	int                   gen_count  = 0;
	int                   gen_total  = 0;

	sorted_list_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.entry     (entry),
		.status    (status),
		.count     (count),
		.is_empty  (is_empty)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit take_gap(int sent);
		return !(sent >= 300 && sent < 460) && ($urandom_range(99) < 17);
	endfunction

	task automatic predict_list_op(func_t f, logic signed [DW-1:0] v, logic [POS_W-1:0] p);
		list_result_t res;
		int at;
		int i;
		res.entry = '0;
		res.st    = ST_OK;
		case (f)
			FN_INSERT: begin
				if (list_len >= DEPTH) begin
					res.st = ST_FULL;
				end else begin
					at = 0;
					while (at < list_len && list_vals[at] < v)
						at++;
					for (i = list_len; i > at; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[at] = v;
					list_len++;
				end
			end
			FN_REMOVE: begin
				if (int'(p) >= list_len) begin
					res.st = ST_BAD_POS;
				end else begin
					for (i = int'(p); i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
				end
			end
			FN_READ: begin
				if (int'(p) >= list_len)
					res.st = ST_BAD_POS;
				else
					res.entry = list_vals[p];
			end
			default: begin
				list_len = 0;
			end
		endcase
		res.cnt   = CW'(list_len);
		res.empty = (list_len == 0);
		results_due.push_back(res);
	endtask

	task automatic add_beat(func_t f, logic signed [DW-1:0] v, logic [POS_W-1:0] p, bit drain);
		op_beat_t b;
		b.f     = f;
		b.v     = v;
		b.p     = p;
		b.drain = drain;
		op_queue.push_back(b);
		gen_total++;
		case (f)
			FN_INSERT: if (gen_count < DEPTH) gen_count++;
			FN_REMOVE: if (int'(p) < gen_count) gen_count--;
			FN_CLEAR:  gen_count = 0;
			default:   ;
		endcase
	endtask

	function automatic logic signed [DW-1:0] pick_value();
		case ($urandom_range(9))
			5, 6:    return DW'($signed($urandom_range(8)) - 4);
			7:       return {1'b0, {(DW-1){1'b1}}} - DW'($urandom_range(2));
			8:       return {1'b1, {(DW-1){1'b0}}} + DW'($urandom_range(2));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if (gen_count > 0 && $urandom_range(9) < 8)
			return POS_W'($urandom_range(gen_count - 1));
		return POS_W'($urandom_range(DEPTH - 1));
	endfunction

	task automatic fill_burst(bit drain);
		int n;
		int k;
		add_beat(FN_CLEAR, pick_value(), pick_position(), drain);
		n = $urandom_range(14, 19);
		for (k = 0; k < n; k++)
			add_beat(FN_INSERT, pick_value(), pick_position(), 1'b0);
		for (k = 0; k < 3; k++)
			add_beat(FN_READ, pick_value(), pick_position(), 1'b0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			func       <= FN_INSERT;
			value      <= '0;
			position   <= '0;
			beats_sent <= 0;
		end else begin
			if (in_valid && in_ready)
				beats_sent <= beats_sent + 1;
			if (!in_valid || in_ready) begin
				if (op_queue.size() == 0 || take_gap(beats_sent) ||
				    (op_queue[0].drain && (results_due.size() != 0 || in_valid))) begin
					in_valid <= 1'b0;
				end else begin
					next_op  = op_queue.pop_front();
					in_valid <= 1'b1;
					func     <= next_op.f;
					value    <= next_op.v;
					position <= next_op.p;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !take_gap(beats_sent);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_list_op(func_t'(func), value, position);
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result beat with none expected: entry %h status %0d count %0d",
						$time, entry, status, count);
					errors++;
				end else begin
					got_due = results_due.pop_front();
					if (entry !== got_due.entry) begin
						$display("%0t: entry expected %h actual %h", $time, got_due.entry, entry);
						errors++;
					end
					if (status !== got_due.st) begin
						$display("%0t: status expected %0d actual %0d", $time, got_due.st, status);
						errors++;
					end
					if (count !== got_due.cnt) begin
						$display("%0t: count expected %0d actual %0d", $time, got_due.cnt, count);
						errors++;
					end
					if (is_empty !== got_due.empty) begin
						$display("%0t: is_empty expected %b actual %b", $time, got_due.empty,
							is_empty);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int kind;
		int k;
		int n;
		int r;
		logic signed [DW-1:0] max_v;
		logic signed [DW-1:0] min_v;
		max_v = {1'b0, {(DW-1){1'b1}}};
		min_v = {1'b1, {(DW-1){1'b0}}};

		add_beat(FN_CLEAR, '0, '0, 1'b0);
		add_beat(FN_READ, '0, 4'd0, 1'b0);
		add_beat(FN_REMOVE, '0, 4'd0, 1'b0);
		add_beat(FN_INSERT, max_v, 4'd15, 1'b0);
		add_beat(FN_INSERT, min_v, 4'd0, 1'b0);
		add_beat(FN_INSERT, '0, 4'd0, 1'b0);
		add_beat(FN_INSERT, '0, 4'd7, 1'b0);
		add_beat(FN_INSERT, -32'sd1, 4'd0, 1'b0);
		add_beat(FN_INSERT, 32'sd1, 4'd0, 1'b0);
		for (k = 0; k < 6; k++)
			add_beat(FN_READ, '1, POS_W'(k), 1'b0);
		add_beat(FN_READ, '0, 4'd6, 1'b0);
		add_beat(FN_REMOVE, '0, 4'd5, 1'b0);
		add_beat(FN_REMOVE, '0, 4'd0, 1'b0);
		add_beat(FN_READ, '0, 4'd15, 1'b0);
		add_beat(FN_REMOVE, '0, 4'd15, 1'b0);
		add_beat(FN_CLEAR, '1, 4'd15, 1'b0);
		add_beat(FN_READ, '0, 4'd0, 1'b0);

		fill_burst(1'b1);
		while (gen_total < 822) begin
			kind = $urandom_range(9);
			if (kind < 2) begin
				fill_burst($urandom_range(1));
			end else if (kind < 4) begin
				n = gen_count + 1;
				for (k = 0; k < n; k++)
					add_beat(FN_REMOVE, pick_value(), pick_position(), 1'b0);
			end else begin
				for (k = 0; k < 20; k++) begin
					r = $urandom_range(99);
					if (r < 38)
						add_beat(FN_INSERT, pick_value(), pick_position(), 1'b0);
					else if (r < 58)
						add_beat(FN_REMOVE, pick_value(), pick_position(), 1'b0);
					else if (r < 96)
						add_beat(FN_READ, pick_value(), pick_position(), 1'b0);
					else
						add_beat(FN_CLEAR, pick_value(), pick_position(), 1'b0);
				end
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (op_queue.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("sorted_list_engine: match");
		else
			$display("sorted_list_engine: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("sorted_list_engine: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/sle_pkg.sv
design/sle_ctrl.sv
design/sle_datapath.sv
design/sorted_list_engine.sv
tb/sv/sorted_list_engine_tb.sv
